FILE: src/vtea_pkg.sv
// Shared types, constants and tables for the vector to elevation/azimuth unit.
`default_nettype none
package vtea_pkg;
  localparam int CW     = 16;
  localparam int AFB    = 16;
  localparam int STAGES = 18;
  localparam int SW     = 62;
  localparam int ZW     = 34;
  localparam int SQW    = 2 * CW + 2;
  localparam int KW     = 5;

  localparam logic signed [ZW-1:0] HALF_PI30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI30      = 34'sd3373259426;
  localparam logic [ZW:0] TWO_PI30 = 35'd6746518852;

  // elevation source
  localparam logic [2:0] EM_ZERO   = 3'd0;
  localparam logic [2:0] EM_POS    = 3'd1;
  localparam logic [2:0] EM_NEG    = 3'd2;
  localparam logic [2:0] EM_CORDIC = 3'd3;

  // azimuth source
  localparam logic [1:0] AM_ZERO = 2'd0;
  localparam logic [1:0] AM_PI   = 2'd1;
  localparam logic [1:0] AM_POS  = 2'd2;
  localparam logic [1:0] AM_NEG  = 2'd3;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0: r = 34'sd843314856;  1: r = 34'sd497837829;
      2: r = 34'sd263043836;  3: r = 34'sd133525158;
      4: r = 34'sd67021686;   5: r = 34'sd33543515;
      6: r = 34'sd16775850;   7: r = 34'sd8388437;
      8: r = 34'sd4194282;    9: r = 34'sd2097149;
      10: r = 34'sd1048575;   11: r = 34'sd524287;
      12: r = 34'sd262143;    13: r = 34'sd131071;
      14: r = 34'sd65535;     15: r = 34'sd32767;
      16: r = 34'sd16383;     17: r = 34'sd8191;
      18: r = 34'sd4095;      19: r = 34'sd2047;
      20: r = 34'sd1023;      21: r = 34'sd511;
      22: r = 34'sd255;       23: r = 34'sd127;
      24: r = 34'sd63;        25: r = 34'sd31;
      26: r = 34'sd15;        27: r = 34'sd7;
      28: r = 34'sd3;         29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // item state carried along the chain
  typedef struct packed {
    logic              vld;
    logic [SQW-1:0]    sq;
    logic [SQW-1:0]    rt;
    logic [SQW-1:0]    bt;
    logic [CW-1:0]     len;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [2*CW:0]     sxy;
  } sq_t;

  typedef struct packed {
    logic signed [SW+1:0] x;
    logic signed [SW+1:0] y;
    logic signed [ZW-1:0] z;
  } cv_t;

  typedef struct packed {
    logic              vld;
    logic [CW-1:0]     len;
    cv_t               e;
    cv_t               a;
    logic [2:0]        emode;
    logic [1:0]        amode;
  } ang_t;
endpackage
`default_nettype wire

FILE: src/vector_to_elevation_azimuth_unit.sv
// Top level: length, elevation and azimuth of a 3D vector, fully pipelined.
//
// Usage: drive in_coord_x/y/z with start high; busy is always low, so one
// vector beat is taken every cycle. Results appear on out_* with out_valid
// high for exactly one cycle, in input order, after passing two square
// stages, 17 root cells, a 33-stage root of the planar sum, normalize,
// 18 CORDIC cells and the output register. Throughput is one vector per
// cycle. The receiver cannot stall; results are never held. cfg_we with
// cfg_data writes the angle deadband (2^-16 rad units); write it only
// while no beat is in flight. Synchronous active-low reset clears every
// valid bit in the pipeline and sets the deadband to 7.
//
`default_nettype none
module vector_to_elevation_azimuth_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire signed [15:0] in_coord_x,
  input  wire signed [15:0] in_coord_y,
  input  wire signed [15:0] in_coord_z,
  input  wire               cfg_we,
  input  wire [15:0]        cfg_data,
  output logic              out_valid,
  output logic [15:0]       out_vec_length,
  output logic signed [17:0] out_elevation,
  output logic [18:0]       out_azimuth
);
  import vtea_pkg::*;
  localparam int LAT_SQ = 32;
  localparam int NSQ = SQW / 2;

  logic [15:0] db_r;
  always_ff @(posedge clk) begin
    if (!rst_n) db_r <= 16'd7;
    else if (cfg_we) db_r <= cfg_data;
  end
  assign busy = 1'b0;

  // stage 0: squares
  sq_t s0_r;
  logic [CW-1:0] ax, ay, az;
  assign ax = in_coord_x[CW-1] ? CW'(-in_coord_x) : in_coord_x;
  assign ay = in_coord_y[CW-1] ? CW'(-in_coord_y) : in_coord_y;
  assign az = in_coord_z[CW-1] ? CW'(-in_coord_z) : in_coord_z;
  logic [2*CW-1:0] px_r, py_r, pz_r;
  logic v0_r;
  logic signed [CW-1:0] x0_r, y0_r, z0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0; else v0_r <= start;
    px_r <= ax * ax; py_r <= ay * ay; pz_r <= az * az;
    x0_r <= in_coord_x; y0_r <= in_coord_y; z0_r <= in_coord_z;
  end
  always_ff @(posedge clk) begin
    s0_r.vld <= v0_r && rst_n;
    s0_r.sxy <= (2*CW+1)'(px_r) + (2*CW+1)'(py_r);
    s0_r.sq  <= SQW'(px_r) + SQW'(py_r) + SQW'(pz_r);
    s0_r.rt  <= '0;
    s0_r.bt  <= SQW'(1) << (SQW - 2);
    s0_r.len <= '0;
    s0_r.x <= x0_r; s0_r.y <= y0_r; s0_r.z <= z0_r;
  end
  sq_t sc [0:NSQ];
  assign sc[0] = s0_r;
  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    vtea_sqrt_cell u_c (.clk(clk), .rst_n(rst_n), .d_in(sc[i]), .d_out(sc[i+1]));
  end

  // planar root: scale sxy by 4^k
  logic [KW-1:0] k_c;
  logic [63:0] s_sc;
  always_comb begin
    k_c = '0;
    for (int j = 0; j < 31; j++) begin
      if (sc[NSQ].sxy < (64'd1 << (62 - 2 * j))) k_c = KW'(j + 1);
    end
    s_sc = 64'(sc[NSQ].sxy) << (2 * k_c);
  end
  sq_t p0;
  always_comb begin
    p0 = sc[NSQ];
    p0.vld = sc[NSQ].vld && rst_n;
    p0.len = sc[NSQ].rt[CW-1:0];
  end
  sq_t p_r [0:LAT_SQ];
  logic [KW-1:0] k_r [0:LAT_SQ];
  always_ff @(posedge clk) begin
    sq_t hop;
    p_r[0] <= p0;
    k_r[0] <= k_c;
    for (int j = 0; j < LAT_SQ; j++) begin
      hop = p_r[j];
      hop.vld = p_r[j].vld && rst_n;
      p_r[j+1] <= hop;
      k_r[j+1] <= k_r[j];
    end
  end
  logic [31:0] rxy;
  vtea_isqrt u_rt (.clk(clk), .n_in(s_sc), .r_out(rxy));
  sq_t pe;
  logic [KW-1:0] ke;
  assign pe = p_r[LAT_SQ];
  assign ke = k_r[LAT_SQ];

  // normalize into [2^59, 2^60)
  function automatic cv_t norm(input logic signed [63:0] a, input logic signed [63:0] b);
    cv_t r;
    logic [63:0] ma, mb, mx;
    logic signed [63:0] xa, xb;
    int sh;
    ma = a[63] ? -a : a; mb = b[63] ? -b : b;
    mx = ma > mb ? ma : mb;
    sh = 0;
    for (int j = 0; j < 64; j++) if (mx[j]) sh = j;
    if (sh >= 59) begin
      xa = a >>> (sh - 59); xb = b >>> (sh - 59);
    end else begin
      xa = a <<< (59 - sh); xb = b <<< (59 - sh);
    end
    r.x = (SW+2)'(xa); r.y = (SW+2)'(xb); r.z = '0;
    return r;
  endfunction
  ang_t n_r;
  logic signed [63:0] zk;
  assign zk = 64'(pe.z) <<< ke;
  always_ff @(posedge clk) begin
    n_r.vld <= pe.vld && rst_n;
    n_r.len <= pe.len;
    n_r.e <= norm($signed({32'd0, rxy}), zk);
    n_r.a <= norm(pe.x[CW-1] ? -64'(pe.x) : 64'(pe.x), 64'(pe.y));
    n_r.emode <= (pe.z == 0) ? EM_ZERO :
                 (pe.sxy == 0) ? (pe.z > 0 ? EM_POS : EM_NEG) : EM_CORDIC;
    n_r.amode <= (pe.y == 0) ? (pe.x[CW-1] ? AM_PI : AM_ZERO) :
                 (pe.x[CW-1] ? AM_NEG : AM_POS);
  end
  ang_t cc [0:STAGES];
  assign cc[0] = n_r;
  for (genvar i = 0; i < STAGES; i++) begin : g_cd
    vtea_cordic_cell u_c (
      .clk(clk), .rst_n(rst_n), .idx(KW'(i)), .d_in(cc[i]), .d_out(cc[i+1])
    );
  end

  function automatic logic signed [ZW:0] to_frac(input logic signed [ZW:0] a);
    logic [ZW:0] m;
    m = a[ZW] ? -a : a;
    m = (m + (35'd1 << (29 - AFB))) >> (30 - AFB);
    return a[ZW] ? -$signed(m) : $signed(m);
  endfunction
  ang_t f;
  logic signed [ZW:0] ef, af, t, half_f;
  logic [ZW:0] ema, ama;
  assign f = cc[STAGES];
  always_comb begin
    half_f = to_frac(35'(HALF_PI30));
    unique case (f.emode)
      EM_ZERO: ef = '0;
      EM_POS:  ef = half_f;
      EM_NEG:  ef = -half_f;
      default: begin
        ef = to_frac(35'(f.e.z));
        if (ef > half_f) ef = half_f;
        if (ef < -half_f) ef = -half_f;
      end
    endcase
    t = '0;
    unique case (f.amode)
      AM_ZERO: af = '0;
      AM_PI:   af = to_frac(35'(PI30));
      AM_POS: begin
        t = 35'(f.a.z);
        if (t < 0) t = t + $signed(TWO_PI30);
        af = to_frac(t);
        if (af > $signed(TWO_PI30 >> (30 - AFB))) af = '0;
      end
      default: begin
        t = 35'(PI30) - 35'(f.a.z);
        af = to_frac(t);
        if (af > $signed(TWO_PI30 >> (30 - AFB))) af = '0;
      end
    endcase
    ema = ef[ZW] ? -ef : ef;
    ama = af[ZW] ? -af : af;
    if (ema < 35'(db_r)) ef = '0;
    if (ama < 35'(db_r)) af = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0; else out_valid <= f.vld;
    out_vec_length <= f.len;
    out_elevation <= ef[17:0];
    out_azimuth <= af[18:0];
  end
`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) !busy) else $error("busy set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");
  a_az: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_azimuth <= 19'd411774) else $error("azimuth range");
`endif
endmodule
`default_nettype wire

FILE: src/vtea_sqrt_cell.sv
// One restoring square root step per cell, two radicand bits per root bit.
`default_nettype none
module vtea_sqrt_cell (
  input  wire            clk,
  input  wire            rst_n,
  input  vtea_pkg::sq_t  d_in,
  output vtea_pkg::sq_t  d_out
);
  import vtea_pkg::*;
  sq_t nxt;
  always_comb begin
    nxt = d_in;
    nxt.vld = d_in.vld && rst_n;
    if (d_in.sq >= d_in.rt + d_in.bt) begin
      nxt.sq = d_in.sq - (d_in.rt + d_in.bt);
      nxt.rt = (d_in.rt >> 1) + d_in.bt;
    end else begin
      nxt.rt = d_in.rt >> 1;
    end
    nxt.bt = d_in.bt >> 2;
  end
  always_ff @(posedge clk) begin
    d_out <= nxt;
  end
endmodule
`default_nettype wire

FILE: src/vtea_isqrt.sv
// Combinational-free wide integer square root (sxy scaled), done as 32 stepped stages.
`default_nettype none
module vtea_isqrt (
  input  wire          clk,
  input  wire [63:0]   n_in,
  output logic [31:0]  r_out
);
  logic [63:0] n_r [0:31];
  logic [63:0] res_r [0:32];
  always_ff @(posedge clk) begin
    n_r[0] <= n_in;
    res_r[0] <= '0;
  end
  for (genvar i = 0; i < 32; i++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic take;
    assign take = n_r[i] >= res_r[i] + BIT;
    always_ff @(posedge clk) begin
      if (take) res_r[i+1] <= (res_r[i] >> 1) + BIT;
      else res_r[i+1] <= res_r[i] >> 1;
    end
    if (i < 31) begin : g_n
      always_ff @(posedge clk) begin
        if (take) n_r[i+1] <= n_r[i] - (res_r[i] + BIT);
        else n_r[i+1] <= n_r[i];
      end
    end
  end
  assign r_out = res_r[32][31:0];
endmodule
`default_nettype wire

FILE: src/vtea_cordic_cell.sv
// One CORDIC vectoring rotation for elevation and azimuth lanes.
`default_nettype none
module vtea_cordic_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire [vtea_pkg::KW-1:0]   idx,
  input  vtea_pkg::ang_t           d_in,
  output vtea_pkg::ang_t           d_out
);
  import vtea_pkg::*;
  function automatic cv_t rot(input cv_t c, input logic [KW-1:0] sh);
    cv_t r;
    logic signed [SW+1:0] dx, dy;
    dx = c.y >>> sh;
    dy = c.x >>> sh;
    r = c;
    if (!c.y[SW+1]) begin
      r.x = c.x + dx; r.y = c.y - dy; r.z = c.z + atan_tab(int'(sh));
    end else begin
      r.x = c.x - dx; r.y = c.y + dy; r.z = c.z - atan_tab(int'(sh));
    end
    return r;
  endfunction
  ang_t nxt;
  always_comb begin
    nxt = d_in;
    nxt.vld = d_in.vld && rst_n;
    nxt.e = rot(d_in.e, idx);
    nxt.a = rot(d_in.a, idx);
  end
  always_ff @(posedge clk) begin
    d_out <= nxt;
  end
endmodule
`default_nettype wire
